>>> rtl/qte_pkg.sv
package qte_pkg;

    localparam int FRAC = 28;
    localparam int TW   = 32;   // saturated term width
    localparam int XW   = 36;   // CORDIC x/y width, covers gain and negation of -2^31
    localparam int SQW  = 58;   // root recurrence width
    localparam int SQ_N = 29;   // root steps, bit 2^56 down to 2^0
    localparam logic signed [XW-1:0] ONE_Q = XW'(64'sd268435456);
    localparam logic [31:0] HALF_TURN = 32'h8000_0000;
    localparam logic [31:0] QTR_POS   = 32'h4000_0000;
    localparam logic [31:0] QTR_NEG   = 32'hC000_0000;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic [31:0]          ang;
        logic                 zero;
    } t_cvec;

    typedef struct packed {
        logic [SQW-1:0] v;
        logic [SQW-1:0] res;
    } t_sqv;

    typedef struct packed {
        logic signed [TW-1:0] sr;
        logic signed [TW-1:0] cr;
        logic signed [TW-1:0] sy;
        logic signed [TW-1:0] cy;
        logic signed [TW-1:0] sp;
        logic                 clamp;
    } t_pass;

    // atan(2^-i) in 2^-32 turn
    function automatic logic [31:0] atan_tab(input int i);
        logic [31:0] t;
        unique case (i)
            0:  t = 32'h20000000;
            1:  t = 32'h12E4051D;
            2:  t = 32'h09FB385B;
            3:  t = 32'h051111D4;
            4:  t = 32'h028B0D43;
            5:  t = 32'h0145D7E1;
            6:  t = 32'h00A2F61E;
            7:  t = 32'h00517C55;
            8:  t = 32'h0028BE53;
            9:  t = 32'h00145F2E;
            10: t = 32'h000A2F98;
            11: t = 32'h000517CC;
            12: t = 32'h00028BE6;
            13: t = 32'h000145F3;
            14: t = 32'h0000A2F9;
            15: t = 32'h0000517C;
            16: t = 32'h000028BE;
            17: t = 32'h0000145F;
            18: t = 32'h00000A2F;
            19: t = 32'h00000517;
            20: t = 32'h0000028B;
            21: t = 32'h00000145;
            22: t = 32'h000000A2;
            23: t = 32'h00000051;
            24: t = 32'h00000028;
            25: t = 32'h00000014;
            26: t = 32'h0000000A;
            27: t = 32'h00000005;
            28: t = 32'h00000002;
            29: t = 32'h00000001;
            default: t = 32'h00000000;
        endcase
        return t;
    endfunction

    function automatic logic signed [TW-1:0] sat32(input logic signed [XW-1:0] v);
        logic signed [TW-1:0] r;
        if (v > XW'(64'sd2147483647))
            r = 32'sh7FFF_FFFF;
        else if (v < -XW'(64'sd2147483648))
            r = 32'sh8000_0000;
        else
            r = TW'(v);
        return r;
    endfunction

    // fold left half-plane onto the right, flag the undefined origin
    function automatic t_cvec prerot(input logic signed [XW-1:0] x,
                                     input logic signed [XW-1:0] y);
        t_cvec c;
        c.zero = (x == '0) && (y == '0);
        if (x < 0) begin
            c.x   = -x;
            c.y   = -y;
            c.ang = HALF_TURN;
        end else begin
            c.x   = x;
            c.y   = y;
            c.ang = '0;
        end
        return c;
    endfunction

endpackage

>>> rtl/qte_sqrt_cell.sv
module qte_sqrt_cell #(
    parameter int STEP = 0
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  qte_pkg::t_sqv  i_sq,
    input  qte_pkg::t_pass i_pass,
    output qte_pkg::t_sqv  o_sq,
    output qte_pkg::t_pass o_pass
);
    import qte_pkg::*;

    localparam int SH = 56 - 2 * STEP;
    localparam logic [SQW-1:0] BIT = SQW'(1) << SH;

    t_sqv n_sq;
    t_sqv r_sq;
    t_pass r_pass;
    logic [SQW-1:0] w_t;

    always_comb begin
        w_t = i_sq.res + BIT;
        if (i_sq.v >= w_t) begin
            n_sq.v   = i_sq.v - w_t;
            n_sq.res = (i_sq.res >> 1) + BIT;
        end else begin
            n_sq.v   = i_sq.v;
            n_sq.res = i_sq.res >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq   <= n_sq;
            r_pass <= i_pass;
        end
    end

    assign o_sq   = r_sq;
    assign o_pass = r_pass;

endmodule

>>> rtl/qte_cordic_cell.sv
module qte_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  qte_pkg::t_cvec i_d,
    output qte_pkg::t_cvec o_d
);
    import qte_pkg::*;

    localparam logic [31:0] ATAN = atan_tab(STAGE);

    t_cvec n_d;
    t_cvec r_d;
    logic signed [XW-1:0] w_xs;
    logic signed [XW-1:0] w_ys;

    always_comb begin
        w_xs = i_d.x >>> STAGE;
        w_ys = i_d.y >>> STAGE;
        n_d.zero = i_d.zero;
        if (i_d.y >= 0) begin
            n_d.x   = i_d.x + w_ys;
            n_d.y   = i_d.y - w_xs;
            n_d.ang = i_d.ang + ATAN;
        end else begin
            n_d.x   = i_d.x - w_ys;
            n_d.y   = i_d.y + w_xs;
            n_d.ang = i_d.ang - ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

>>> rtl/quaternion_to_euler_angles.sv
// Pipeline stages: products, terms, square, 29 root cells, fold, CORDIC cells,
// output register.
// Throughput: one beat per cycle; every stage advances together, so a stalled
// output holds the whole pipe.
// Reset (synchronous, active low) clears the valid bits only; no clearing pass.
module quaternion_to_euler_angles #(
    parameter int COMPONENT_WIDTH = 16,
    parameter int ANGLE_WIDTH     = 16,
    parameter int CORDIC_STAGES   = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [COMPONENT_WIDTH-1:0] i_quat_w,
    input  logic signed [COMPONENT_WIDTH-1:0] i_quat_x,
    input  logic signed [COMPONENT_WIDTH-1:0] i_quat_y,
    input  logic signed [COMPONENT_WIDTH-1:0] i_quat_z,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [ANGLE_WIDTH-1:0]     o_roll_angle,
    output logic signed [ANGLE_WIDTH-1:0]     o_pitch_angle,
    output logic signed [ANGLE_WIDTH-1:0]     o_yaw_angle,
    output logic                              o_pitch_clamped
);
    import qte_pkg::*;

    localparam int CW    = COMPONENT_WIDTH;
    localparam int PW    = 2 * CW;
    localparam int D     = 2 * (CW - 2) - FRAC;
    localparam int D_POS = (D >= 0) ? D : 0;
    localparam int D_NEG = (D < 0) ? -D : 0;
    localparam int CS    = CORDIC_STAGES;
    localparam int NV    = 3 + SQ_N + 1 + CS + 1;
    localparam int SH    = 32 - ANGLE_WIDTH;
    localparam logic [31:0] RND = 32'((33'(1) << SH) >> 1);
    localparam logic signed [ANGLE_WIDTH-1:0] QTR = ANGLE_WIDTH'(1) << (ANGLE_WIDTH - 2);

    localparam int P_WX = 0, P_YZ = 1, P_XX = 2, P_YY = 3, P_WY = 4;
    localparam int P_ZX = 5, P_WZ = 6, P_XY = 7, P_ZZ = 8, NP = 9;

    logic w_en;
    logic [NV-1:0] r_vld;

    assign w_en    = !(r_vld[NV-1] && i_stall);
    assign o_stall = !w_en;
    assign o_valid = r_vld[NV-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NV-2:0], i_valid};
        end
    end

    // products, scaled to 28 fraction bits
    logic signed [CW-1:0] w_a [NP];
    logic signed [CW-1:0] w_b [NP];
    logic signed [PW-1:0] w_p [NP];
    logic signed [TW-1:0] n_prod [NP];
    logic signed [TW-1:0] r_prod [NP];

    always_comb begin
        w_a[P_WX] = i_quat_w; w_b[P_WX] = i_quat_x;
        w_a[P_YZ] = i_quat_y; w_b[P_YZ] = i_quat_z;
        w_a[P_XX] = i_quat_x; w_b[P_XX] = i_quat_x;
        w_a[P_YY] = i_quat_y; w_b[P_YY] = i_quat_y;
        w_a[P_WY] = i_quat_w; w_b[P_WY] = i_quat_y;
        w_a[P_ZX] = i_quat_z; w_b[P_ZX] = i_quat_x;
        w_a[P_WZ] = i_quat_w; w_b[P_WZ] = i_quat_z;
        w_a[P_XY] = i_quat_x; w_b[P_XY] = i_quat_y;
        w_a[P_ZZ] = i_quat_z; w_b[P_ZZ] = i_quat_z;
        for (int k = 0; k < NP; k++) begin
            w_p[k] = w_a[k] * w_b[k];
            if (D >= 0)
                n_prod[k] = TW'(w_p[k] >>> D_POS);
            else
                n_prod[k] = TW'(w_p[k]) <<< D_NEG;
        end
    end

    // saturated terms
    function automatic logic signed [XW-1:0] ext(input logic signed [TW-1:0] v);
        return XW'(v);
    endfunction

    t_pass n_pass2;
    t_pass r_pass2;

    always_comb begin
        n_pass2.sr = sat32(2 * (ext(r_prod[P_WX]) + ext(r_prod[P_YZ])));
        n_pass2.cr = sat32(ONE_Q - 2 * (ext(r_prod[P_XX]) + ext(r_prod[P_YY])));
        n_pass2.sp = sat32(2 * (ext(r_prod[P_WY]) - ext(r_prod[P_ZX])));
        n_pass2.sy = sat32(2 * (ext(r_prod[P_WZ]) + ext(r_prod[P_XY])));
        n_pass2.cy = sat32(ONE_Q - 2 * (ext(r_prod[P_YY]) + ext(r_prod[P_ZZ])));
        n_pass2.clamp = 1'b0;
    end

    // pole check and sine square
    logic                  w_clamp;
    logic signed [28:0]    w_sp29;
    logic signed [57:0]    w_sq;
    logic [56:0]           r_sq;
    t_pass                 r_pass3;

    always_comb begin
        w_clamp = (ext(r_pass2.sp) >= ONE_Q) || (ext(r_pass2.sp) <= -ONE_Q);
        w_sp29  = w_clamp ? '0 : r_pass2.sp[28:0];
        w_sq    = w_sp29 * w_sp29;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_prod  <= n_prod;
            r_pass2 <= n_pass2;
            r_sq    <= w_sq[56:0];
            r_pass3 <= '{sr: r_pass2.sr, cr: r_pass2.cr, sy: r_pass2.sy,
                         cy: r_pass2.cy, sp: r_pass2.sp, clamp: w_clamp};
        end
    end

    // root cells: c = floor(sqrt(2^56 - sp^2))
    t_sqv  w_sqv  [SQ_N+1];
    t_pass w_ps   [SQ_N+1];

    assign w_sqv[0].v   = SQW'((57'(1) << 56) - r_sq);
    assign w_sqv[0].res = '0;
    assign w_ps[0]      = r_pass3;

    for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
        qte_sqrt_cell #(.STEP(k)) u_cell (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_sq   (w_sqv[k]),
            .i_pass (w_ps[k]),
            .o_sq   (w_sqv[k+1]),
            .o_pass (w_ps[k+1])
        );
    end

    // fold into the right half-plane
    t_cvec r_fr, r_fp, r_fy;
    logic [1:0] r_flag [CS+1];   // {clamp, pitch sign}

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fr <= prerot(ext(w_ps[SQ_N].cr), ext(w_ps[SQ_N].sr));
            r_fp <= prerot(XW'(w_sqv[SQ_N].res), ext(w_ps[SQ_N].sp));
            r_fy <= prerot(ext(w_ps[SQ_N].cy), ext(w_ps[SQ_N].sy));
            r_flag[0] <= {w_ps[SQ_N].clamp, w_ps[SQ_N].sp[TW-1]};
            for (int k = 0; k < CS; k++)
                r_flag[k+1] <= r_flag[k];
        end
    end

    t_cvec w_cr [CS+1];
    t_cvec w_cp [CS+1];
    t_cvec w_cy [CS+1];

    assign w_cr[0] = r_fr;
    assign w_cp[0] = r_fp;
    assign w_cy[0] = r_fy;

    for (genvar s = 0; s < CS; s++) begin : g_cordic
        qte_cordic_cell #(.STAGE(s)) u_roll (
            .i_clk (i_clk), .i_en (w_en), .i_d (w_cr[s]), .o_d (w_cr[s+1])
        );
        qte_cordic_cell #(.STAGE(s)) u_pitch (
            .i_clk (i_clk), .i_en (w_en), .i_d (w_cp[s]), .o_d (w_cp[s+1])
        );
        qte_cordic_cell #(.STAGE(s)) u_yaw (
            .i_clk (i_clk), .i_en (w_en), .i_d (w_cy[s]), .o_d (w_cy[s+1])
        );
    end

    // select, round half up, output register
    logic [31:0] w_ar, w_ap, w_ay;
    logic [31:0] w_rr, w_rp, w_ry;

    always_comb begin
        w_ar = w_cr[CS].zero ? '0 : w_cr[CS].ang;
        w_ay = w_cy[CS].zero ? '0 : w_cy[CS].ang;
        if (r_flag[CS][1])
            w_ap = r_flag[CS][0] ? QTR_NEG : QTR_POS;
        else
            w_ap = w_cp[CS].zero ? '0 : w_cp[CS].ang;
        w_rr = w_ar + RND;
        w_rp = w_ap + RND;
        w_ry = w_ay + RND;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_roll_angle    <= w_rr[31 -: ANGLE_WIDTH];
            o_pitch_angle   <= w_rp[31 -: ANGLE_WIDTH];
            o_yaw_angle     <= w_ry[31 -: ANGLE_WIDTH];
            o_pitch_clamped <= r_flag[CS][1];
        end
    end

    a_clamp_quarter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_pitch_clamped |-> (o_pitch_angle == QTR) || (o_pitch_angle == -QTR))
        else $error("clamped pitch is not a quarter turn");

    a_stall_only_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == (o_valid && i_stall))
        else $error("input stall without a blocked output beat");

    a_pipe_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_roll_angle) && $stable(o_yaw_angle))
        else $error("output beat lost during stall");

endmodule

>>> tb/quaternion_to_euler_angles_chk.sv
module quaternion_to_euler_angles_chk (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               o_stall,
    input  logic signed [15:0] i_quat_w,
    input  logic signed [15:0] i_quat_x,
    input  logic signed [15:0] i_quat_y,
    input  logic signed [15:0] i_quat_z,
    input  logic               o_valid,
    input  logic               i_stall,
    input  logic signed [15:0] o_roll_angle,
    input  logic signed [15:0] o_pitch_angle,
    input  logic signed [15:0] o_yaw_angle,
    input  logic               o_pitch_clamped,
    output int                 errors,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int       ROTATIONS = 16;
    localparam longint   UNIT      = 64'sd1 << 28;

    typedef struct packed {
        logic [15:0] roll;
        logic [15:0] pitch;
        logic [15:0] yaw;
        logic        clamped;
    } euler_t;

    // atan(2^-i), 2^-32 turn units
    localparam logic [31:0] ATAN_STEP [16] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C
    };

    euler_t expected_angles[$];

    function automatic longint clip32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic logic [31:0] vector_angle(input longint sy, input longint sx);
        logic [31:0] ang;
        longint      xs;
        longint      ys;
        ang = '0;
        if (sx == 0 && sy == 0)
            return '0;
        if (sx < 0) begin
            ang = 32'h8000_0000;
            sx  = -sx;
            sy  = -sy;
        end
        for (int i = 0; i < ROTATIONS; i++) begin
            xs = sx >>> i;
            ys = sy >>> i;
            if (sy >= 0) begin
                sx  = sx + ys;
                sy  = sy - xs;
                ang = ang + ATAN_STEP[i];
            end else begin
                sx  = sx - ys;
                sy  = sy + xs;
                ang = ang - ATAN_STEP[i];
            end
        end
        return ang;
    endfunction

    function automatic longint unsigned root_floor(input longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b   = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [15:0] to_bam(input logic [31:0] a);
        logic [31:0] r;
        r = a + 32'h0000_8000;
        return r[31:16];
    endfunction

    function automatic euler_t euler_from_quat(input logic signed [15:0] qw,
                                               input logic signed [15:0] qx,
                                               input logic signed [15:0] qy,
                                               input logic signed [15:0] qz);
        longint      w, x, y, z, sr, cr, sp, sy, cy, c;
        logic [31:0] pa;
        euler_t      e;
        w  = qw;
        x  = qx;
        y  = qy;
        z  = qz;
        // Q14 * Q14 is already Q28
        sr = clip32(2 * (w * x + y * z));
        cr = clip32(UNIT - 2 * (x * x + y * y));
        sp = clip32(2 * (w * y - z * x));
        sy = clip32(2 * (w * z + x * y));
        cy = clip32(UNIT - 2 * (y * y + z * z));
        e.clamped = 1'b0;
        if (sp >= UNIT) begin
            pa        = 32'h4000_0000;
            e.clamped = 1'b1;
        end else if (sp <= -UNIT) begin
            pa        = 32'hC000_0000;
            e.clamped = 1'b1;
        end else begin
            c  = longint'(root_floor(longint'(UNIT * UNIT - sp * sp)));
            pa = vector_angle(sp, c);
        end
        e.roll  = to_bam(vector_angle(sr, cr));
        e.pitch = to_bam(pa);
        e.yaw   = to_bam(vector_angle(sy, cy));
        return e;
    endfunction

    assign pending = expected_angles.size();

    initial errors = 0;

    always @(posedge i_clk) begin
        euler_t want;
        euler_t got;
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                expected_angles.push_back(euler_from_quat(i_quat_w, i_quat_x,
                                                          i_quat_y, i_quat_z));
            if (o_valid && !i_stall) begin
                got = '{o_roll_angle, o_pitch_angle, o_yaw_angle, o_pitch_clamped};
                if (expected_angles.size() == 0) begin
                    errors = errors + 1;
                    if (errors <= 10)
                        $display("unexpected output beat: roll %0d pitch %0d yaw %0d",
                                 $signed(got.roll), $signed(got.pitch),
                                 $signed(got.yaw));
                end else begin
                    want = expected_angles.pop_front();
                    if (want != got) begin
                        errors = errors + 1;
                        if (errors <= 10)
                            $display("angle error: want r %0d p %0d y %0d c %0d, %s %0d %0d %0d %0d",
                                     $signed(want.roll), $signed(want.pitch),
                                     $signed(want.yaw), want.clamped, "got",
                                     $signed(got.roll), $signed(got.pitch),
                                     $signed(got.yaw), got.clamped);
                    end
                end
            end
        end
    end

endmodule

>>> tb/quaternion_to_euler_angles_tb.sv
module quaternion_to_euler_angles_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 4000;
    localparam int LATENCY     = 50;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               i_stall = 1'b0;
    logic signed [15:0] i_quat_w = '0;
    logic signed [15:0] i_quat_x = '0;
    logic signed [15:0] i_quat_y = '0;
    logic signed [15:0] i_quat_z = '0;
    logic               o_stall;
    logic               o_valid;
    logic signed [15:0] o_roll_angle;
    logic signed [15:0] o_pitch_angle;
    logic signed [15:0] o_yaw_angle;
    logic               o_pitch_clamped;

    int errors;
    int pending;
    int quats_taken = 0;
    int quiet_cycles = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;
    bit calm = 1'b0;

    always #5 i_clk = ~i_clk;

    quaternion_to_euler_angles DUT (.*);

    quaternion_to_euler_angles_chk u_chk (.*);

    always @(posedge i_clk) begin
        if (i_valid && !o_stall)
            quats_taken <= quats_taken + 1;
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("quaternion_to_euler_angles: mismatch");
            $finish;
        end
    end

    always @(negedge i_clk)
        i_stall <= !calm && ($urandom_range(0, 99) < stall_pct);

    task automatic send_quat(input logic [15:0] w, input logic [15:0] x,
                             input logic [15:0] y, input logic [15:0] z);
        int target;
        while (!calm && $urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_quat_w <= w;
        i_quat_x <= x;
        i_quat_y <= y;
        i_quat_z <= z;
        i_valid  <= 1'b1;
        target = quats_taken + 1;
        do
            @(negedge i_clk);
        while (quats_taken != target);
    endtask

    task automatic send_random_quat;
        int          kind;
        logic [15:0] r;
        logic [15:0] q[4];
        kind = $urandom_range(0, 99);
        if (kind < 20) begin
            for (int k = 0; k < 4; k++)
                q[k] = 16'($urandom);
        end else if (kind < 70) begin
            for (int k = 0; k < 4; k++)
                q[k] = 16'($urandom_range(0, 32768) - 16384);
        end else if (kind < 90) begin
            // close to the pitch pole
            r    = 16'($urandom_range(11000, 12200));
            q[0] = $urandom_range(0, 1) ? r : -r;
            q[2] = $urandom_range(0, 1) ? r : -r;
            q[1] = 16'($urandom_range(0, 800) - 400);
            q[3] = 16'($urandom_range(0, 800) - 400);
        end else begin
            for (int k = 0; k < 4; k++)
                q[k] = 16'($urandom_range(0, 64) - 32);
        end
        send_quat(q[0], q[1], q[2], q[3]);
    endtask

    task automatic drain;
        i_valid <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (LATENCY + 10) @(negedge i_clk);
    endtask

    initial begin
        int idle_cfg[4];
        int stall_cfg[4];
        idle_cfg  = '{0, 86, 0, 28};
        stall_cfg = '{0, 0, 86, 28};
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_quat(16'sd16384, 16'sd0, 16'sd0, 16'sd0);
        send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_quat(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_quat(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
        send_quat(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
        send_quat(16'sd11585, 16'sd0, 16'sd11585, 16'sd0);
        send_quat(16'sd11586, 16'sd0, 16'sd11586, 16'sd0);
        send_quat(16'sd11585, 16'sd0, -16'sd11585, 16'sd0);
        send_quat(16'sd0, 16'sd11585, 16'sd0, 16'sd11585);
        send_quat(16'sd0, 16'sd16384, 16'sd0, 16'sd0);
        send_quat(16'sd0, -16'sd16384, 16'sd0, 16'sd0);
        send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd16384);
        send_quat(16'sd0, 16'sd0, 16'sd16384, 16'sd0);
        // roll arguments both zero, then yaw arguments both zero
        send_quat(16'sd0, 16'sd8192, 16'sd8192, 16'sd0);
        send_quat(16'sd0, 16'sd0, 16'sd8192, 16'sd8192);
        send_quat(16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192);
        send_quat(-16'sd8192, 16'sd8192, -16'sd8192, 16'sd8192);
        send_quat(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
        send_quat(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
        send_quat(16'sd1, 16'sd0, 16'sd0, -16'sd1);
        send_quat(-16'sd1, -16'sd1, -16'sd1, -16'sd1);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = idle_cfg[ph];
            stall_pct     = stall_cfg[ph];
            for (int n = 0; n < 400; n++) begin
                if (n % 50 == 0)
                    calm = ($urandom_range(0, 3) == 0);
                send_random_quat();
            end
            calm = 1'b0;
            drain();
        end

        if (errors == 0 && pending == 0)
            $display("quaternion_to_euler_angles: match");
        else
            $display("quaternion_to_euler_angles: mismatch");
        $finish;
    end

endmodule
